// ===== hdl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    localparam int unsigned AddrWidth    = 16;
    localparam int unsigned DataWidth    = 8;
    localparam int unsigned RomOutWidth  = 19;
    localparam int unsigned RomRawWidth  = 21;
    localparam int unsigned PrgOffWidth  = 13;
    localparam int unsigned ChrOffWidth  = 10;
    localparam int unsigned CountWidth   = 16;

    localparam logic [AddrWidth-1:0] RegMirrorLo = 16'h42FE;
    localparam logic [AddrWidth-1:0] RegMirrorHi = 16'h42FF;
    localparam logic [AddrWidth-1:0] RegIrqAck   = 16'h4501;
    localparam logic [AddrWidth-1:0] RegCountLo  = 16'h4502;
    localparam logic [AddrWidth-1:0] RegCountHi  = 16'h4503;
    localparam logic [AddrWidth-1:0] RegPrgBank  = 16'h4504;
    localparam logic [AddrWidth-1:0] RegChrBank  = 16'h4510;

    localparam logic [DataWidth-1:0] PrgBankLastReset = 8'hFF;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TICK     = 2'd1,
        OP_PRG_READ = 2'd2,
        OP_CHR_READ = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_MIRROR,
        CMD_IRQ_ACK,
        CMD_COUNT_LO,
        CMD_COUNT_HI,
        CMD_PRG_BANK,
        CMD_CHR_BANK,
        CMD_TICK,
        CMD_PRG_READ,
        CMD_CHR_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [2:0]             index;
        logic [DataWidth-1:0]   data;
        logic [PrgOffWidth-1:0] offset;
    } cmd_t;

endpackage

// ===== hdl/cbm_if.sv =====
// Valid/ready channel interfaces for mapper items and results.
interface cbm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  cycles;

    modport source (output valid, output opcode, output address, output write_data,
                    output cycles, input ready);
    modport sink (input valid, input opcode, input address, input write_data,
                  input cycles, output ready);
endinterface

interface cbm_result_if;
    logic        valid;
    logic        ready;
    logic [18:0] rom_address;
    logic [1:0]  mirroring;
    logic        irq_line;

    modport source (output valid, output rom_address, output mirroring, output irq_line,
                    input ready);
    modport sink (input valid, input rom_address, input mirroring, input irq_line,
                  output ready);
endinterface

// ===== hdl/cbm_front.sv =====
// Front end: accepts item beats and decodes them into mapper commands.
module cbm_front (
    cbm_item_if.sink     item,
    input  logic         full,
    output logic         push,
    output cbm_pkg::cmd_t push_cmd
);
    import cbm_pkg::*;

    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        push_cmd        = '0;
        push_cmd.kind   = CMD_NOP;
        push_cmd.index  = item.address[2:0];
        push_cmd.data   = item.write_data;
        push_cmd.offset = item.address[PrgOffWidth-1:0];
        case (opcode_t'(item.opcode))
            OP_WRITE:
            begin
                if (item.address == RegMirrorLo || item.address == RegMirrorHi)
                begin
                    push_cmd.kind = CMD_MIRROR;
                    push_cmd.data = {6'd0, item.address[0], item.write_data[4]};
                end
                else if (item.address == RegIrqAck)
                begin
                    push_cmd.kind = CMD_IRQ_ACK;
                end
                else if (item.address == RegCountLo)
                begin
                    push_cmd.kind = CMD_COUNT_LO;
                end
                else if (item.address == RegCountHi)
                begin
                    push_cmd.kind = CMD_COUNT_HI;
                end
                else if (item.address[AddrWidth-1:2] == RegPrgBank[AddrWidth-1:2])
                begin
                    push_cmd.kind = CMD_PRG_BANK;
                end
                else if (item.address[AddrWidth-1:3] == RegChrBank[AddrWidth-1:3])
                begin
                    push_cmd.kind = CMD_CHR_BANK;
                end
            end
            OP_TICK:
            begin
                push_cmd.kind = CMD_TICK;
                push_cmd.data = item.cycles;
            end
            OP_PRG_READ:
            begin
                if (item.address[AddrWidth-1])
                begin
                    push_cmd.kind  = CMD_PRG_READ;
                    push_cmd.index = {1'b0, item.address[14:13]};
                end
            end
            OP_CHR_READ:
            begin
                push_cmd.kind   = CMD_CHR_READ;
                push_cmd.index  = item.address[12:10];
                push_cmd.offset = {3'd0, item.address[ChrOffWidth-1:0]};
            end
            default:
            begin
                push_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

// ===== hdl/cbm_queue.sv =====
// Two-entry command queue between the decode front end and the execute back end.
module cbm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cbm_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output cbm_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import cbm_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/cbm_back.sv =====
// Back end: holds the bank, mirroring and counter state and registers each result beat.
module cbm_back #(
    parameter int unsigned ROM_ADDR_BITS = 19
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  cbm_pkg::cmd_t pop_cmd,
    output logic          pop,
    cbm_result_if.source  result
);
    import cbm_pkg::*;

    localparam logic [RomRawWidth-1:0] RomMask =
        RomRawWidth'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    logic [DataWidth-1:0]   prg_bank_reg [4];
    logic [DataWidth-1:0]   chr_bank_reg [8];
    logic [1:0]             mirror_reg;
    logic [1:0]             mirror_next;
    logic                   enable_reg;
    logic                   enable_next;
    logic [CountWidth-1:0]  counter_reg;
    logic [CountWidth-1:0]  counter_next;
    logic                   irq_reg;
    logic                   irq_next;
    logic                   out_valid_reg;
    logic [RomOutWidth-1:0] rom_reg;
    logic [RomOutWidth-1:0] rom_next;
    logic [CountWidth:0]    tick_sum;
    logic [RomRawWidth-1:0] rom_raw;

    assign pop                = !empty && (!out_valid_reg || result.ready);
    assign result.valid       = out_valid_reg;
    assign result.rom_address = rom_reg;
    assign result.mirroring   = mirror_reg;
    assign result.irq_line    = irq_reg;

    assign tick_sum = {1'b0, counter_reg} + {{(CountWidth + 1 - DataWidth){1'b0}}, pop_cmd.data};

    always_comb
    begin
        mirror_next  = mirror_reg;
        enable_next  = enable_reg;
        counter_next = counter_reg;
        irq_next     = irq_reg;
        rom_raw      = '0;
        case (pop_cmd.kind)
            CMD_MIRROR:
            begin
                mirror_next = pop_cmd.data[1:0];
            end
            CMD_IRQ_ACK:
            begin
                enable_next = 1'b0;
                irq_next    = 1'b0;
            end
            CMD_COUNT_LO:
            begin
                counter_next = {counter_reg[CountWidth-1:DataWidth], pop_cmd.data};
            end
            CMD_COUNT_HI:
            begin
                counter_next = {pop_cmd.data, counter_reg[DataWidth-1:0]};
                enable_next  = 1'b1;
            end
            CMD_TICK:
            begin
                if (enable_reg)
                begin
                    if (tick_sum[CountWidth])
                    begin
                        irq_next     = 1'b1;
                        enable_next  = 1'b0;
                        counter_next = '0;
                    end
                    else
                    begin
                        counter_next = tick_sum[CountWidth-1:0];
                    end
                end
            end
            CMD_PRG_READ:
            begin
                rom_raw = {prg_bank_reg[pop_cmd.index[1:0]], pop_cmd.offset};
            end
            CMD_CHR_READ:
            begin
                rom_raw = {3'd0, chr_bank_reg[pop_cmd.index],
                           pop_cmd.offset[ChrOffWidth-1:0]};
            end
            default:
            begin
                rom_raw = '0;
            end
        endcase
        rom_next = RomOutWidth'(rom_raw & RomMask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_reg[0] <= '0;
            prg_bank_reg[1] <= '0;
            prg_bank_reg[2] <= '0;
            prg_bank_reg[3] <= PrgBankLastReset;
            for (int i = 0; i < 8; i++)
            begin
                chr_bank_reg[i] <= '0;
            end
            mirror_reg    <= '0;
            enable_reg    <= 1'b0;
            counter_reg   <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mirror_reg  <= mirror_next;
                enable_reg  <= enable_next;
                counter_reg <= counter_next;
                irq_reg     <= irq_next;
                if (pop_cmd.kind == CMD_PRG_BANK)
                begin
                    prg_bank_reg[pop_cmd.index[1:0]] <= pop_cmd.data;
                end
                if (pop_cmd.kind == CMD_CHR_BANK)
                begin
                    chr_bank_reg[pop_cmd.index] <= pop_cmd.data;
                end
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rom_reg <= rom_next;
        end
    end

endmodule

// ===== hdl/cartridge_bank_mapper_irq.sv =====
// Top level of the cartridge bank mapper with cycle-counting interrupt.
//
//   Channel  Role    Beat carries
//   item     sink    opcode, address, write_data, cycles
//   result   source  rom_address, mirroring, irq_line
//
// One item per clock is sustained while result is ready. An accepted item is
// decoded and written into the queue; from there it is executed into the output
// register, which drives the beat on result. The two-entry queue lets item accept
// two more beats while result is stalled, and then item is held until result frees.
// Reset is asynchronous and brings the banks, counter and interrupt to their
// power-on values at once.
module cartridge_bank_mapper_irq #(
    parameter int unsigned ROM_ADDR_BITS = 19
) (
    input  logic          clk,
    input  logic          rst_n,
    cbm_item_if.sink      item,
    cbm_result_if.source  result
);
    import cbm_pkg::*;

    logic full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t pop_cmd;
    logic empty;

    cbm_front u_front (
        .item     (item),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cbm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    cbm_back #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (empty),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .result  (result)
    );

endmodule
